// ===== src/b64lw_pkg.sv =====
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the symbol lookup for the line-wrapped
// base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

    localparam int JOB_MAX   = 8;
    localparam int IDX_W     = $clog2(JOB_MAX);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;

    // One request for the back end: the characters it must emit, in order.
    typedef struct packed {
        logic [JOB_MAX-1:0][7:0] chars;
        logic [IDX_W-1:0]        last_idx;
        logic                    fin;
    } job_t;

    typedef struct packed {
        logic                 valid;
        logic                 full;
        logic [Q_CNT_W-1:0]   count;
    } q_status_t;

    function automatic logic [7:0] b64_sym(input logic [5:0] six);
        logic [7:0] s;
        s = {2'b00, six};
        if (six < 6'd26)
            return 8'h41 + s;
        else if (six < 6'd52)
            return 8'h61 + s - 8'd26;
        else if (six < 6'd62)
            return 8'h30 + s - 8'd52;
        else if (six == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

// ===== src/base64_line_wrapped_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Base64 encoder with CR LF line wrapping, one raw byte per request.
// ----------------------------------------------------------------------------
// A byte that completes or ends a group sends its request through the queue
// to the output register; other bytes produce no output.
// Throughput: one byte per cycle while the two-entry request queue has room;
// output is one character per cycle from the back-end sequencer while pop is high.
// Reset clears the held bytes, the line count and the request queue; line_length
// returns to 76.
module base64_line_wrapped_encoder
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       line_length_we,
    input  logic [7:0] line_length_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       message_end
);

    logic [7:0] line_length_reg;
    logic       enq;
    logic       deq;
    job_t       enq_job;
    job_t       head;
    q_status_t  q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_length_reg <= LINE_LENGTH_RESET;
        else if (line_length_we)
            line_length_reg <= line_length_wdata;
    end

    assign full = q_status.full;

    b64lw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .in_byte     (in_byte),
        .final_byte  (final_byte),
        .line_length (line_length_reg),
        .q_full      (q_status.full),
        .enq         (enq),
        .enq_job     (enq_job)
    );

    b64lw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_job (enq_job),
        .deq     (deq),
        .head    (head),
        .status  (q_status)
    );

    b64lw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (q_status.valid),
        .deq         (deq),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .run_last    (run_last),
        .message_end (message_end)
    );

    // The closing LF of a message is always the last character of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && message_end) |-> (run_last && out_char == CHAR_LF))
        else $error("message end not on closing LF");

    // The queue count never passes its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("request queue overflow");

    // A waiting character that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(run_last)))
        else $error("output changed while waiting");

endmodule

// ===== src/b64lw_front.sv =====
// ----------------------------------------------------------------------------
// b64lw_front
// Accepts bytes, collects 3-byte groups, tracks the line count and builds
// one character request per byte that produces output.
// ----------------------------------------------------------------------------
module b64lw_front
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    input  logic [7:0] line_length,
    input  logic       q_full,
    output logic       enq,
    output job_t       enq_job
);

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  gc_reg, gc_next;
    logic [7:0]  lc_reg, lc_next;

    logic        accept;
    logic [7:0]  b0, b1;
    logic [8:0]  lc_sum;
    logic        wrap;

    assign accept = push && !q_full;
    assign b0     = pend_reg[15:8];
    assign b1     = pend_reg[7:0];
    assign lc_sum = {1'b0, lc_reg} + 9'd4;
    assign wrap   = (line_length != 8'd0) && (lc_sum >= {1'b0, line_length});

    always_comb
    begin
        pend_next = pend_reg;
        gc_next   = gc_reg;
        lc_next   = lc_reg;
        enq       = 1'b0;
        enq_job   = '0;
        // Positions four to seven always hold CR LF CR LF; the last index
        // decides how many of them go out.
        enq_job.chars[4] = CHAR_CR;
        enq_job.chars[5] = CHAR_LF;
        enq_job.chars[6] = CHAR_CR;
        enq_job.chars[7] = CHAR_LF;
        enq_job.fin      = final_byte;
        enq_job.last_idx = IDX_W'(5);
        if (accept)
        begin
            if (gc_reg >= 2'd2)
            begin
                enq = 1'b1;
                enq_job.chars[0] = b64_sym(b0[7:2]);
                enq_job.chars[1] = b64_sym({b0[1:0], b1[7:4]});
                enq_job.chars[2] = b64_sym({b1[3:0], in_byte[7:6]});
                enq_job.chars[3] = b64_sym(in_byte[5:0]);
                enq_job.last_idx = IDX_W'(3 + (wrap ? 2 : 0) + (final_byte ? 2 : 0));
                lc_next   = wrap ? 8'd0 : lc_sum[7:0];
                pend_next = '0;
                gc_next   = 2'd0;
            end
            else if (!final_byte)
            begin
                if (gc_reg == 2'd0)
                    pend_next = {in_byte, 8'h00};
                else
                    pend_next = {b0, in_byte};
                gc_next = gc_reg + 2'd1;
            end
            else if (gc_reg == 2'd0)
            begin
                enq = 1'b1;
                enq_job.chars[0] = b64_sym(in_byte[7:2]);
                enq_job.chars[1] = b64_sym({in_byte[1:0], 4'b0000});
                enq_job.chars[2] = CHAR_PAD;
                enq_job.chars[3] = CHAR_PAD;
            end
            else
            begin
                enq = 1'b1;
                enq_job.chars[0] = b64_sym(b0[7:2]);
                enq_job.chars[1] = b64_sym({b0[1:0], in_byte[7:4]});
                enq_job.chars[2] = b64_sym({in_byte[3:0], 2'b00});
                enq_job.chars[3] = CHAR_PAD;
            end
            if (final_byte)
            begin
                pend_next = '0;
                gc_next   = 2'd0;
                lc_next   = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            gc_reg   <= '0;
            lc_reg   <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            gc_reg   <= gc_next;
            lc_reg   <= lc_next;
        end
    end

endmodule

// ===== src/b64lw_queue.sv =====
// ----------------------------------------------------------------------------
// b64lw_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64lw_queue
    import b64lw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enq,
    input  job_t      enq_job,
    input  logic      deq,
    output job_t      head,
    output q_status_t status
);

    job_t                mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                do_enq, do_deq;

    assign status.valid = (cnt_reg != '0);
    assign status.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign status.count = cnt_reg;
    assign head         = mem[rd_ptr_reg];

    assign do_enq = enq && !status.full;
    assign do_deq = deq && status.valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_enq && !do_deq)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (!do_enq && do_deq)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_enq)
            mem[wr_ptr_reg] <= enq_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_enq)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + Q_PTR_W'(1);
            if (do_deq)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/b64lw_back.sv =====
// ----------------------------------------------------------------------------
// b64lw_back
// Walks the head request one character per cycle into the output register while it is free or popped.
// ----------------------------------------------------------------------------
module b64lw_back
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       head_valid,
    output logic       deq,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       message_end
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       char_reg;
    logic             run_last_reg;
    logic             msg_end_reg;
    logic             load_ok;
    logic             step;
    logic             at_last;

    // The output register takes a new character when it is free or is
    // being emptied in this cycle.
    assign load_ok = !out_valid_reg || pop;
    assign step    = head_valid && load_ok;
    assign at_last = (idx_reg == head.last_idx);
    assign deq     = step && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load_ok)
            out_valid_next = head_valid;
        if (step)
            idx_next = at_last ? '0 : idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            char_reg     <= head.chars[idx_reg];
            run_last_reg <= at_last;
            msg_end_reg  <= at_last && head.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_char    = char_reg;
    assign run_last    = run_last_reg;
    assign message_end = msg_end_reg;

endmodule

// ===== sim/tb_base64_line_wrapped_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_base64_line_wrapped_encoder
// Self-checking bench for the line-wrapped base64 encoder. Raw bytes are
// pushed in messages, every popped character is compared with a predicted
// character stream, and the line length is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_base64_line_wrapped_encoder;
    import b64lw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;
    localparam int PHASE_BUDGET = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       mend;
    } enc_char_t;

    // Predicts the character stream and checks popped characters against it.
    class encoder_scoreboard;
        string       alpha;
        logic [7:0]  line_len;
        logic [15:0] held;
        logic [1:0]  n_held;
        logic [7:0]  col;
        enc_char_t   due_q[$];
        int          n_err;
        int          n_chars;
        int          n_bytes;
        int          n_msgs;

        function new();
            alpha    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            line_len = LINE_LENGTH_RESET;
            held     = '0;
            n_held   = '0;
            col      = '0;
            n_err    = 0;
            n_chars  = 0;
            n_bytes  = 0;
            n_msgs   = 0;
        endfunction

        function void put(logic [7:0] c);
            enc_char_t e;
            e.ch   = c;
            e.last = 1'b0;
            e.mend = 1'b0;
            due_q.push_back(e);
        endfunction

        function void put_sym(logic [5:0] s);
            put(alpha[s]);
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            logic [7:0] b0;
            logic [7:0] b1;
            logic [8:0] next_col;
            b0 = held[15:8];
            b1 = held[7:0];
            n_bytes++;
            if (n_held == 2'd2) begin
                put_sym(b0[7:2]);
                put_sym({b0[1:0], b1[7:4]});
                put_sym({b1[3:0], b[7:6]});
                put_sym(b[5:0]);
                // The compare is done one bit wider so long lines still wrap.
                next_col = {1'b0, col} + 9'd4;
                if (line_len != 8'd0 && next_col >= {1'b0, line_len}) begin
                    put(CHAR_CR);
                    put(CHAR_LF);
                    next_col = '0;
                end
                col    = next_col[7:0];
                held   = '0;
                n_held = '0;
                if (fin) begin
                    put(CHAR_CR);
                    put(CHAR_LF);
                end
            end else if (!fin) begin
                if (n_held == 2'd0)
                    held = {b, 8'h00};
                else
                    held[7:0] = b;
                n_held = n_held + 2'd1;
                return;
            end else if (n_held == 2'd0) begin
                put_sym(b[7:2]);
                put_sym({b[1:0], 4'h0});
                put(CHAR_PAD);
                put(CHAR_PAD);
                put(CHAR_CR);
                put(CHAR_LF);
            end else begin
                put_sym(b0[7:2]);
                put_sym({b0[1:0], b[7:4]});
                put_sym({b[3:0], 2'b00});
                put(CHAR_PAD);
                put(CHAR_CR);
                put(CHAR_LF);
            end
            if (fin) begin
                held   = '0;
                n_held = '0;
                col    = '0;
                n_msgs++;
                due_q[due_q.size() - 1].mend = 1'b1;
            end
            due_q[due_q.size() - 1].last = 1'b1;
        endfunction

        function void check_char(logic [7:0] c, logic last, logic mend);
            enc_char_t e;
            if (due_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected character %h last=%b end=%b",
                             c, last, mend);
                return;
            end
            e = due_q.pop_front();
            n_chars++;
            if (c !== e.ch || last !== e.last || mend !== e.mend) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: char %0d expected %h/%b/%b got %h/%b/%b",
                             n_chars, e.ch, e.last, e.mend, c, last, mend);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       line_length_we = 1'b0;
    logic [7:0] line_length_wdata = 8'd0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_byte = 8'd0;
    logic       final_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;

    int tx_idle_pct = 21;
    int rx_idle_pct = 55;
    int cycle_count = 0;

    encoder_scoreboard sb;

    base64_line_wrapped_encoder u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .line_length_we    (line_length_we),
        .line_length_wdata (line_length_wdata),
        .push              (push),
        .full              (full),
        .in_byte           (in_byte),
        .final_byte        (final_byte),
        .empty             (empty),
        .pop               (pop),
        .out_char          (out_char),
        .run_last          (run_last),
        .message_end       (message_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Requests are noted before results are checked in the same edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.note_byte(in_byte, final_byte);
            if (pop && !empty)
                sb.check_char(out_char, run_last, message_end);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_base64_line_wrapped_encoder failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        in_byte    <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.due_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_line_length(input logic [7:0] v);
        line_length_we    <= 1'b1;
        line_length_wdata <= v;
        @(negedge clk);
        line_length_we <= 1'b0;
        sb.line_len = v;
    endtask

    task automatic send_message(input int len, input bit finish);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), finish && (i == len - 1));
    endtask

    task automatic run_phase();
        int budget;
        int msg_len;
        budget = PHASE_BUDGET;
        while (budget > 0) begin
            if ($urandom_range(0, 7) == 0)
                msg_len = $urandom_range(10, 40);
            else
                msg_len = $urandom_range(1, 9);
            if (msg_len > budget) begin
                // A cut-off message may leave bytes held and the line count running across the next setting.
                send_message(budget, 1'b0);
                budget = 0;
            end else begin
                send_message(msg_len, 1'b1);
                budget = budget - msg_len;
            end
            if ($urandom_range(0, 29) == 0)
                drain();
        end
    endtask

    initial
    begin
        logic [7:0] phase_len[6];
        sb = new();
        phase_len = '{8'd0, 8'd252, 8'd255, 8'd1, 8'd76, 8'd0};
        phase_len[5] = 8'($urandom_range(2, 251));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset value of the line length, single and double padding,
        // full groups of all-zero and all-one bytes.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        // Wrap after every group, and the closing CR LF right after a wrap.
        write_line_length(8'd4);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);
        drain();

        // Length changed mid-message to a value the count already passed.
        write_line_length(8'd0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        drain();
        write_line_length(8'd1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                tx_idle_pct = 21;
                rx_idle_pct = 55;
            end else if (p < 4) begin
                tx_idle_pct = 55;
                rx_idle_pct = 21;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_line_length(phase_len[p]);
            run_phase();
            drain();
        end

        drain();
        repeat (20) @(negedge clk);

        $display("Run covered %0d bytes in %0d complete messages, %0d characters checked,",
                 sb.n_bytes, sb.n_msgs, sb.n_chars);
        $display("with wrapping off, at 1, 4, 76, 252, 255 and a random line length.");
        if (sb.due_q.size() != 0) begin
            $display("ERROR: %0d expected characters never arrived", sb.due_q.size());
            sb.n_err++;
        end
        if (sb.n_err == 0) begin
            $display("tb_base64_line_wrapped_encoder passed");
        end else begin
            $display("%0d mismatches in total", sb.n_err);
            $display("tb_base64_line_wrapped_encoder failed");
        end
        $finish;
    end

endmodule
